// ----- src/ppu_tsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_tsa_pkg: shared types and constants of the video timing and scroll unit
// Holds the operation codes, the frame phases, the structs that pass between
// the timing counters and the register file, and the address update helpers.
// ----------------------------------------------------------------------------
package ppu_tsa_pkg;

  // Operation carried by one input transfer.
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_CTRL_WR    = 3'd1,
    OP_MASK_WR    = 3'd2,
    OP_STATUS_RD  = 3'd3,
    OP_SCROLL_WR  = 3'd4,
    OP_ADDR_WR    = 3'd5,
    OP_DATA_RD    = 3'd6,
    OP_DATA_WR    = 3'd7
  } op_e;

  // Frame phases walked by the dot ticks.
  typedef enum logic [1:0] {
    PH_PRE    = 2'd0,
    PH_RENDER = 2'd1,
    PH_POST   = 2'd2,
    PH_VBLANK = 2'd3
  } phase_e;

  // Address field masks of the scroll registers.
  localparam logic [15:0] MaskCopyH    = 16'h041F;
  localparam logic [15:0] MaskCopyV    = 16'h7BE0;
  localparam logic [15:0] MaskFineY    = 16'h7000;
  localparam logic [15:0] MaskCoarseY  = 16'h03E0;
  localparam logic [15:0] MaskCoarseX  = 16'h001F;
  localparam logic [15:0] MaskScrollY  = 16'h73E0;
  localparam logic [15:0] NtSelectV    = 16'h0800;
  localparam logic [15:0] NtSelectH    = 16'h0400;
  localparam logic [15:0] FineYOne     = 16'h1000;
  localparam logic [15:0] IncOne       = 16'h0001;
  localparam logic [15:0] IncRow       = 16'h0020;
  localparam logic [13:0] PaletteBase  = 14'h3F00;
  localparam logic [4:0]  CoarseYLast  = 5'd29;
  localparam logic [4:0]  CoarseMax    = 5'd31;
  localparam logic [2:0]  FineXLast    = 3'd7;

  // Prerender dots on which the vertical scroll bits are reloaded.
  localparam logic [8:0]  DotVertFirst = 9'd280;
  localparam logic [8:0]  DotVertLast  = 9'd304;

  // Rendering switches from the mask register.
  typedef struct packed {
    logic bg_on;
    logic spr_on;
  } mode_t;

  // Per-dot events decoded from the frame counters.
  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       clear_flags;
    logic       copy_h;
    logic       copy_v;
    logic       bump_y;
    logic       vblank_start;
  } tick_evt_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  read_value;
    logic [15:0] access_address;
    logic        write_enable;
    logic [15:0] vram_address;
    logic [2:0]  fine_x;
    logic        nmi;
    logic        vblank;
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } result_t;

  // Step coarse X, moving to the next horizontal name table on wrap.
  function automatic logic [15:0] bump_coarse_x(input logic [15:0] a);
    logic [15:0] r;
    if (a[4:0] == CoarseMax) begin
      r = (a & ~MaskCoarseX) ^ NtSelectH;
    end else begin
      r = a + IncOne;
    end
    return r;
  endfunction

  // Step fine Y, carrying into coarse Y and the vertical name table.
  function automatic logic [15:0] bump_fine_y(input logic [15:0] a);
    logic [15:0] r;
    logic [4:0]  cy;
    r  = a;
    cy = a[9:5];
    if ((a & MaskFineY) != MaskFineY) begin
      r = a + FineYOne;
    end else begin
      r = a & ~MaskFineY;
      if (cy == CoarseYLast) begin
        cy = '0;
        r  = r ^ NtSelectV;
      end else if (cy == CoarseMax) begin
        cy = '0;
      end else begin
        cy = cy + 5'd1;
      end
      r = (r & ~MaskCoarseY) | {6'd0, cy, 5'd0};
    end
    return r;
  endfunction

endpackage

// ----- src/ppu_tsa_top.sv -----
// ----------------------------------------------------------------------------
// ppu_timing_and_scroll_address: video timing and scroll address unit
// Steps the frame timing on dot ticks and serves the register accesses of
// the scroll, address, control, mask, status and data ports.
// ----------------------------------------------------------------------------
// Usage: every input transfer carries one operation (a dot tick or one
// register access) on op_i with its value_i, bus_data_i and
// sprite_zero_seen_i; every transfer yields exactly one result transfer.
// Both channels use valid/stall: a transfer happens on a rising edge with
// valid high and stall low.
// An item enters the input register at the edge it is taken, and its
// result is then loaded into the result register, which drives out_valid_o.
// Throughput: one item per cycle when the receiver does not stall. The state
// update of an item (counters, address register, flags) completes in the
// same cycle that registers its result, so the next item already sees it;
// the single combinational pass through the timing decode and the address
// update sets the clock period. When the receiver stalls, the result
// register holds and the input register takes one more item; in_stall_o
// then rises until the result is taken. Reset empties both registers and
// loads the register file and the frame counters with their power-up
// values: rendering switches on, prerender phase, even frame.
module ppu_timing_and_scroll_address #(
  parameter int unsigned VISIBLE_DOTS   = 256,
  parameter int unsigned LINE_END_DOT   = 340,
  parameter int unsigned VISIBLE_LINES  = 240,
  parameter int unsigned FRAME_END_LINE = 261
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  value_i,
  input  logic [7:0]  bus_data_i,
  input  logic        sprite_zero_seen_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_value_o,
  output logic [15:0] access_address_o,
  output logic        write_enable_o,
  output logic [15:0] vram_address_o,
  output logic [2:0]  fine_x_o,
  output logic        nmi_o,
  output logic        vblank_o,
  output logic        pixel_valid_o,
  output logic [7:0]  pixel_x_o,
  output logic [7:0]  pixel_y_o
);

  // Input register.
  logic       in_valid_q;
  logic [2:0] op_q;
  logic [7:0] value_q;
  logic [7:0] bus_data_q;
  logic       seen_q;

  // Result register.
  logic                 out_valid_q;
  ppu_tsa_pkg::result_t res_q;

  ppu_tsa_pkg::result_t   res;
  ppu_tsa_pkg::tick_evt_t evt;
  ppu_tsa_pkg::mode_t     mode;
  ppu_tsa_pkg::op_e       op;

  logic advance;
  logic fire;
  logic take_in;

  // The result register can load when it is empty or its content leaves now.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;
  assign op         = ppu_tsa_pkg::op_e'(op_q);

  ppu_tsa_timing #(
    .VISIBLE_DOTS  (VISIBLE_DOTS),
    .LINE_END_DOT  (LINE_END_DOT),
    .VISIBLE_LINES (VISIBLE_LINES),
    .FRAME_END_LINE(FRAME_END_LINE)
  ) u_timing (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tick_i(fire && op == ppu_tsa_pkg::OP_TICK),
    .mode_i(mode),
    .evt_o (evt)
  );

  ppu_tsa_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (fire),
    .op_i              (op),
    .value_i           (value_q),
    .bus_data_i        (bus_data_q),
    .sprite_zero_seen_i(seen_q),
    .evt_i             (evt),
    .mode_o            (mode),
    .res_o             (res)
  );

  // Valid bits of the two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload of the two registers.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q       <= op_i;
      value_q    <= value_i;
      bus_data_q <= bus_data_i;
      seen_q     <= sprite_zero_seen_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = res_q.read_value;
  assign access_address_o = res_q.access_address;
  assign write_enable_o   = res_q.write_enable;
  assign vram_address_o   = res_q.vram_address;
  assign fine_x_o         = res_q.fine_x;
  assign nmi_o            = res_q.nmi;
  assign vblank_o         = res_q.vblank;
  assign pixel_valid_o    = res_q.pixel_valid;
  assign pixel_x_o        = res_q.pixel_x;
  assign pixel_y_o        = res_q.pixel_y;

endmodule

// ----- src/ppu_tsa_timing.sv -----
// ----------------------------------------------------------------------------
// ppu_tsa_timing: dot, line and frame phase counters
// Decodes the current dot into scroll and flag events and advances the
// counters on every tick that is carried out.
// ----------------------------------------------------------------------------
module ppu_tsa_timing #(
  parameter int unsigned VISIBLE_DOTS   = 256,
  parameter int unsigned LINE_END_DOT   = 340,
  parameter int unsigned VISIBLE_LINES  = 240,
  parameter int unsigned FRAME_END_LINE = 261
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_i,
  input  ppu_tsa_pkg::mode_t    mode_i,
  output ppu_tsa_pkg::tick_evt_t evt_o
);

  localparam logic [8:0] DotVisLast   = 9'(VISIBLE_DOTS);
  localparam logic [8:0] DotBumpY     = 9'(VISIBLE_DOTS + 1);
  localparam logic [8:0] DotCopyH     = 9'(VISIBLE_DOTS + 2);
  localparam logic [8:0] DotLineEnd   = 9'(LINE_END_DOT);
  localparam logic [8:0] LineVisEnd   = 9'(VISIBLE_LINES);
  localparam logic [8:0] LineVblStart = 9'(VISIBLE_LINES + 1);
  localparam logic [8:0] LineFrameEnd = 9'(FRAME_END_LINE);

  logic [8:0]          dot_q, dot_d;
  logic [8:0]          line_q, line_d;
  ppu_tsa_pkg::phase_e phase_q, phase_d;
  logic                even_q, even_d;

  logic       rendering;
  logic       line_done;
  logic [8:0] line_inc;

  assign rendering = mode_i.bg_on & mode_i.spr_on;
  assign line_inc  = line_q + 9'd1;

  always_comb begin
    evt_o     = '0;
    line_d    = line_q;
    phase_d   = phase_q;
    even_d    = even_q;
    line_done = 1'b0;
    case (phase_q)
      ppu_tsa_pkg::PH_PRE: begin
        if (dot_q == 9'd1) begin
          evt_o.clear_flags = 1'b1;
        end else if (dot_q == DotCopyH && rendering) begin
          evt_o.copy_h = 1'b1;
        end else if (dot_q > ppu_tsa_pkg::DotVertFirst &&
                     dot_q <= ppu_tsa_pkg::DotVertLast && rendering) begin
          evt_o.copy_v = 1'b1;
        end
        // The prerender line is one dot short on odd frames while rendering.
        if (dot_q >= DotLineEnd - 9'(!even_q && rendering)) begin
          phase_d   = ppu_tsa_pkg::PH_RENDER;
          line_done = 1'b1;
          line_d    = '0;
        end
      end
      ppu_tsa_pkg::PH_RENDER: begin
        if (dot_q != 9'd0 && dot_q <= DotVisLast) begin
          evt_o.pixel_valid = 1'b1;
          evt_o.pixel_x     = 8'(dot_q - 9'd1);
          evt_o.pixel_y     = line_q[7:0];
        end else if (dot_q == DotBumpY && mode_i.bg_on) begin
          evt_o.bump_y = 1'b1;
        end else if (dot_q == DotCopyH && rendering) begin
          evt_o.copy_h = 1'b1;
        end
        if (dot_q >= DotLineEnd) begin
          line_done = 1'b1;
          line_d    = line_inc;
        end
        if (line_d >= LineVisEnd) begin
          phase_d = ppu_tsa_pkg::PH_POST;
        end
      end
      ppu_tsa_pkg::PH_POST: begin
        if (dot_q >= DotLineEnd) begin
          line_done = 1'b1;
          line_d    = line_inc;
          phase_d   = ppu_tsa_pkg::PH_VBLANK;
        end
      end
      ppu_tsa_pkg::PH_VBLANK: begin
        if (dot_q == 9'd1 && line_q == LineVblStart) begin
          evt_o.vblank_start = 1'b1;
        end
        if (dot_q >= DotLineEnd) begin
          line_done = 1'b1;
          line_d    = line_inc;
        end
        if (line_d >= LineFrameEnd) begin
          phase_d = ppu_tsa_pkg::PH_PRE;
          line_d  = '0;
          even_d  = ~even_q;
        end
      end
      default: begin
        phase_d = ppu_tsa_pkg::PH_PRE;
      end
    endcase
    dot_d = (line_done ? 9'd0 : dot_q) + 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= '0;
      line_q  <= '0;
      phase_q <= ppu_tsa_pkg::PH_PRE;
      even_q  <= 1'b1;
    end else if (tick_i) begin
      dot_q   <= dot_d;
      line_q  <= line_d;
      phase_q <= phase_d;
      even_q  <= even_d;
    end
  end

endmodule

// ----- src/ppu_tsa_regs.sv -----
// ----------------------------------------------------------------------------
// ppu_tsa_regs: scroll address, control, mask and status registers
// Applies one operation to the register file and forms its result item.
// ----------------------------------------------------------------------------
module ppu_tsa_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ppu_tsa_pkg::op_e       op_i,
  input  logic [7:0]             value_i,
  input  logic [7:0]             bus_data_i,
  input  logic                   sprite_zero_seen_i,
  input  ppu_tsa_pkg::tick_evt_t evt_i,
  output ppu_tsa_pkg::mode_t     mode_o,
  output ppu_tsa_pkg::result_t   res_o
);

  logic [15:0] cur_q, cur_d;
  logic [15:0] temp_q, temp_d;
  logic [2:0]  fine_q, fine_d;
  logic        first_q, first_d;
  logic        vblank_q, vblank_d;
  logic        hit_q, hit_d;
  logic        irq_q, irq_d;
  logic        step32_q, step32_d;
  logic        bg_q, bg_d;
  logic        spr_q, spr_d;
  logic [7:0]  rbuf_q, rbuf_d;

  logic [15:0] inc;
  logic [15:0] temp_lo;
  logic [2:0]  xf;
  logic        dot_visible;

  assign inc         = step32_q ? ppu_tsa_pkg::IncRow : ppu_tsa_pkg::IncOne;
  assign xf          = fine_q + evt_i.pixel_x[2:0];
  assign dot_visible = (op_i == ppu_tsa_pkg::OP_TICK) && evt_i.pixel_valid;
  assign temp_lo     = {temp_q[15:8], value_i};
  assign mode_o      = '{bg_on: bg_q, spr_on: spr_q};

  always_comb begin
    cur_d    = cur_q;
    temp_d   = temp_q;
    fine_d   = fine_q;
    first_d  = first_q;
    vblank_d = vblank_q;
    hit_d    = hit_q;
    irq_d    = irq_q;
    step32_d = step32_q;
    bg_d     = bg_q;
    spr_d    = spr_q;
    rbuf_d   = rbuf_q;
    res_o    = '0;
    case (op_i)
      ppu_tsa_pkg::OP_TICK: begin
        if (evt_i.clear_flags) begin
          vblank_d = 1'b0;
          hit_d    = 1'b0;
        end
        if (evt_i.vblank_start) begin
          vblank_d  = 1'b1;
          res_o.nmi = irq_q;
        end
        if (evt_i.pixel_valid) begin
          res_o.pixel_valid = 1'b1;
          res_o.pixel_x     = evt_i.pixel_x;
          res_o.pixel_y     = evt_i.pixel_y;
          if (bg_q && xf == ppu_tsa_pkg::FineXLast) begin
            cur_d = ppu_tsa_pkg::bump_coarse_x(cur_q);
          end
          if (bg_q && spr_q && sprite_zero_seen_i) begin
            hit_d = 1'b1;
          end
        end
        if (evt_i.bump_y) begin
          cur_d = ppu_tsa_pkg::bump_fine_y(cur_q);
        end
        if (evt_i.copy_h) begin
          cur_d = (cur_q & ~ppu_tsa_pkg::MaskCopyH) | (temp_q & ppu_tsa_pkg::MaskCopyH);
        end
        if (evt_i.copy_v) begin
          cur_d = (cur_q & ~ppu_tsa_pkg::MaskCopyV) | (temp_q & ppu_tsa_pkg::MaskCopyV);
        end
      end
      ppu_tsa_pkg::OP_CTRL_WR: begin
        irq_d          = value_i[7];
        step32_d       = value_i[2];
        temp_d[11:10]  = value_i[1:0];
      end
      ppu_tsa_pkg::OP_MASK_WR: begin
        bg_d  = value_i[3];
        spr_d = value_i[4];
      end
      ppu_tsa_pkg::OP_STATUS_RD: begin
        res_o.read_value = {vblank_q, hit_q, 6'd0};
        vblank_d         = 1'b0;
        first_d          = 1'b1;
      end
      ppu_tsa_pkg::OP_SCROLL_WR: begin
        if (first_q) begin
          temp_d[4:0] = value_i[7:3];
          fine_d      = value_i[2:0];
          first_d     = 1'b0;
        end else begin
          temp_d  = (temp_q & ~ppu_tsa_pkg::MaskScrollY) |
                    {1'b0, value_i[2:0], 2'b00, value_i[7:3], 5'd0};
          first_d = 1'b1;
        end
      end
      ppu_tsa_pkg::OP_ADDR_WR: begin
        if (first_q) begin
          temp_d  = {2'b00, value_i[5:0], temp_q[7:0]};
          first_d = 1'b0;
        end else begin
          temp_d  = temp_lo;
          cur_d   = temp_lo;
          first_d = 1'b1;
        end
      end
      ppu_tsa_pkg::OP_DATA_RD: begin
        res_o.access_address = cur_q;
        // Reads below the palette area come out of the one-byte buffer.
        if (cur_q[13:0] < ppu_tsa_pkg::PaletteBase) begin
          res_o.read_value = rbuf_q;
          rbuf_d           = bus_data_i;
        end else begin
          res_o.read_value = bus_data_i;
        end
        cur_d = cur_q + inc;
      end
      ppu_tsa_pkg::OP_DATA_WR: begin
        res_o.access_address = cur_q;
        res_o.write_enable   = 1'b1;
        cur_d                = cur_q + inc;
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
    res_o.vram_address = cur_d;
    res_o.vblank       = vblank_d;
    res_o.fine_x       = dot_visible ? xf : fine_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      temp_q   <= '0;
      fine_q   <= '0;
      first_q  <= 1'b1;
      vblank_q <= 1'b0;
      hit_q    <= 1'b0;
      irq_q    <= 1'b0;
      step32_q <= 1'b0;
      bg_q     <= 1'b1;
      spr_q    <= 1'b1;
      rbuf_q   <= '0;
    end else if (en_i) begin
      cur_q    <= cur_d;
      temp_q   <= temp_d;
      fine_q   <= fine_d;
      first_q  <= first_d;
      vblank_q <= vblank_d;
      hit_q    <= hit_d;
      irq_q    <= irq_d;
      step32_q <= step32_d;
      bg_q     <= bg_d;
      spr_q    <= spr_d;
      rbuf_q   <= rbuf_d;
    end
  end

endmodule

// ----- dv/ppu_timing_and_scroll_address_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppu_timing_and_scroll_address_tb: self-checking bench of the timing unit
// Walks a short table of register accesses and ticks, steps the address
// register across the mirror boundary above the palette, then mixes random
// accesses under random idling with stall-free tick runs through the first
// lines of the frame. Every result transfer is compared field by field with
// an in-bench prediction, or with the result typed into the table for its row.
// ----------------------------------------------------------------------------
module ppu_timing_and_scroll_address_tb;

  // Frame geometry, kept equal to the values handed to the block.
  localparam int unsigned VisibleDots  = 256;
  localparam int unsigned LineEndDot   = 340;
  localparam int unsigned VisibleLines = 240;
  localparam int unsigned FrameEndLine = 261;

  // Address bits reloaded from the temporary address.
  localparam logic [15:0] HorzBits     = 16'h041F;
  localparam logic [15:0] VertBits     = 16'h7BE0;
  localparam logic [13:0] PaletteStart = 14'h3F00;

  typedef struct {
    ppu_tsa_pkg::op_e     op;
    logic [7:0]           val;
    logic [7:0]           bus;
    logic                 seen;
    logic                 typed;
    ppu_tsa_pkg::result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [7:0]  value_i;
  logic [7:0]  bus_data_i;
  logic        sprite_zero_seen_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_value_o;
  logic [15:0] access_address_o;
  logic        write_enable_o;
  logic [15:0] vram_address_o;
  logic [2:0]  fine_x_o;
  logic        nmi_o;
  logic        vblank_o;
  logic        pixel_valid_o;
  logic [7:0]  pixel_x_o;
  logic [7:0]  pixel_y_o;

  ppu_timing_and_scroll_address #(
    .VISIBLE_DOTS  (VisibleDots),
    .LINE_END_DOT  (LineEndDot),
    .VISIBLE_LINES (VisibleLines),
    .FRAME_END_LINE(FrameEndLine)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .value_i           (value_i),
    .bus_data_i        (bus_data_i),
    .sprite_zero_seen_i(sprite_zero_seen_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_value_o      (read_value_o),
    .access_address_o  (access_address_o),
    .write_enable_o    (write_enable_o),
    .vram_address_o    (vram_address_o),
    .fine_x_o          (fine_x_o),
    .nmi_o             (nmi_o),
    .vblank_o          (vblank_o),
    .pixel_valid_o     (pixel_valid_o),
    .pixel_x_o         (pixel_x_o),
    .pixel_y_o         (pixel_y_o)
  );

  // Predicted copy of the unit's state.
  logic [15:0]         vid_addr, tmp_addr;
  logic [2:0]          fine_scroll_q;
  logic                first_wr;
  logic [8:0]          dot_q, line_q;
  ppu_tsa_pkg::phase_e phase_q;
  logic                even_q, vbl_q, hit_q, nmi_en_q, inc32_q, bg_q, spr_q;
  logic [7:0]          rd_buf_q;

  ppu_tsa_pkg::result_t due_results[$];
  stim_row_t            directed_rows[$];
  int unsigned          mismatches;
  int unsigned          items_sent;

  // Set while a stretch without idling runs on both sides.
  logic        quiet;

  // Expectation typed into the table for the item now offered, if any.
  logic                 row_typed;
  ppu_tsa_pkg::result_t row_want;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] merge_bits(input logic [15:0] dst, input logic [15:0] src,
                                             input logic [15:0] mask);
    return (dst & ~mask) | (src & mask);
  endfunction

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic ppu_tsa_pkg::result_t plain_result(input logic [7:0] rd,
                                                        input logic [15:0] acc,
                                                        input logic we,
                                                        input logic [15:0] va,
                                                        input logic [2:0] fx);
    ppu_tsa_pkg::result_t r;
    r                = '0;
    r.read_value     = rd;
    r.access_address = acc;
    r.write_enable   = we;
    r.vram_address   = va;
    r.fine_x         = fx;
    return r;
  endfunction

  // Applies one item to the predicted state and returns the result it yields.
  function automatic ppu_tsa_pkg::result_t advance_video_state(input ppu_tsa_pkg::op_e op,
                                                               input logic [7:0] v,
                                                               input logic [7:0] bus,
                                                               input logic seen);
    ppu_tsa_pkg::result_t r;
    logic        rendering;
    int unsigned d, x;
    logic [2:0]  xf;
    logic [4:0]  cy;
    logic [15:0] step;
    r         = '0;
    rendering = bg_q && spr_q;
    d         = dot_q;
    step      = inc32_q ? 16'h0020 : 16'h0001;
    case (op)
      ppu_tsa_pkg::OP_TICK: begin
        case (phase_q)
          ppu_tsa_pkg::PH_PRE: begin
            if (d == 1) begin
              vbl_q = 1'b0;
              hit_q = 1'b0;
            end else if (d == VisibleDots + 2 && rendering) begin
              vid_addr = merge_bits(vid_addr, tmp_addr, HorzBits);
            end else if (d > 280 && d <= 304 && rendering) begin
              vid_addr = merge_bits(vid_addr, tmp_addr, VertBits);
            end
            // Odd frames with rendering on drop the last prerender dot.
            if (d + ((!even_q && rendering) ? 1 : 0) >= LineEndDot) begin
              phase_q = ppu_tsa_pkg::PH_RENDER;
              dot_q   = '0;
              line_q  = '0;
            end
          end
          ppu_tsa_pkg::PH_RENDER: begin
            if (d >= 1 && d <= VisibleDots) begin
              x             = d - 1;
              xf            = fine_scroll_q + x[2:0];
              r.pixel_valid = 1'b1;
              r.pixel_x     = x[7:0];
              r.pixel_y     = line_q[7:0];
              r.fine_x      = xf;
              if (bg_q && xf == 3'd7) begin
                if (vid_addr[4:0] == 5'd31) begin
                  vid_addr = (vid_addr & ~16'h001F) ^ 16'h0400;
                end else begin
                  vid_addr = vid_addr + 16'd1;
                end
              end
              if (rendering && seen) hit_q = 1'b1;
            end else if (d == VisibleDots + 1 && bg_q) begin
              // Fine Y step, carrying into coarse Y and the vertical table.
              if (vid_addr[14:12] != 3'd7) begin
                vid_addr = vid_addr + 16'h1000;
              end else begin
                cy               = vid_addr[9:5];
                vid_addr[14:12]  = 3'd0;
                if (cy == 5'd29) begin
                  cy           = '0;
                  vid_addr[11] = ~vid_addr[11];
                end else if (cy == 5'd31) begin
                  cy = '0;
                end else begin
                  cy = cy + 5'd1;
                end
                vid_addr[9:5] = cy;
              end
            end else if (d == VisibleDots + 2 && rendering) begin
              vid_addr = merge_bits(vid_addr, tmp_addr, HorzBits);
            end
            if (d >= LineEndDot) begin
              line_q = line_q + 9'd1;
              dot_q  = '0;
            end
            if (line_q >= VisibleLines) phase_q = ppu_tsa_pkg::PH_POST;
          end
          ppu_tsa_pkg::PH_POST: begin
            if (d >= LineEndDot) begin
              line_q  = line_q + 9'd1;
              dot_q   = '0;
              phase_q = ppu_tsa_pkg::PH_VBLANK;
            end
          end
          default: begin
            if (d == 1 && line_q == VisibleLines + 1) begin
              vbl_q = 1'b1;
              if (nmi_en_q) r.nmi = 1'b1;
            end
            if (d >= LineEndDot) begin
              line_q = line_q + 9'd1;
              dot_q  = '0;
            end
            if (line_q >= FrameEndLine) begin
              phase_q = ppu_tsa_pkg::PH_PRE;
              line_q  = '0;
              even_q  = ~even_q;
            end
          end
        endcase
        dot_q = dot_q + 9'd1;
      end
      ppu_tsa_pkg::OP_CTRL_WR: begin
        nmi_en_q        = v[7];
        inc32_q         = v[2];
        tmp_addr[11:10] = v[1:0];
      end
      ppu_tsa_pkg::OP_MASK_WR: begin
        bg_q  = v[3];
        spr_q = v[4];
      end
      ppu_tsa_pkg::OP_STATUS_RD: begin
        r.read_value = {vbl_q, hit_q, 6'd0};
        vbl_q        = 1'b0;
        first_wr     = 1'b1;
      end
      ppu_tsa_pkg::OP_SCROLL_WR: begin
        if (first_wr) begin
          tmp_addr[4:0] = v[7:3];
          fine_scroll_q = v[2:0];
        end else begin
          tmp_addr[14:12] = v[2:0];
          tmp_addr[9:5]   = v[7:3];
        end
        first_wr = ~first_wr;
      end
      ppu_tsa_pkg::OP_ADDR_WR: begin
        if (first_wr) begin
          tmp_addr = {2'b00, v[5:0], tmp_addr[7:0]};
        end else begin
          tmp_addr[7:0] = v;
          vid_addr      = tmp_addr;
        end
        first_wr = ~first_wr;
      end
      ppu_tsa_pkg::OP_DATA_RD: begin
        r.access_address = vid_addr;
        // Reads below the palette come out of the one-byte delay buffer.
        if (vid_addr[13:0] < PaletteStart) begin
          r.read_value = rd_buf_q;
          rd_buf_q     = bus;
        end else begin
          r.read_value = bus;
        end
        vid_addr = vid_addr + step;
      end
      default: begin
        r.access_address = vid_addr;
        r.write_enable   = 1'b1;
        vid_addr         = vid_addr + step;
      end
    endcase
    r.vram_address = vid_addr;
    r.vblank       = vbl_q;
    if (!r.pixel_valid) r.fine_x = fine_scroll_q;
    return r;
  endfunction

  task automatic add_row(input ppu_tsa_pkg::op_e op, input logic [7:0] val,
                         input logic [7:0] bus, input logic seen, input logic typed,
                         input ppu_tsa_pkg::result_t want);
    stim_row_t row;
    row.op    = op;
    row.val   = val;
    row.bus   = bus;
    row.seen  = seen;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one item after a drawn gap and returns at the falling edge that
  // follows its transfer.
  task automatic send_item(input ppu_tsa_pkg::op_e op, input logic [7:0] val,
                           input logic [7:0] bus, input logic seen, input logic typed,
                           input ppu_tsa_pkg::result_t want);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    op_i               = op;
    value_i            = val;
    bus_data_i         = bus;
    sprite_zero_seen_i = seen;
    row_typed          = typed;
    row_want           = want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input ppu_tsa_pkg::op_e op);
    send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Result side: draws a stall for each result, then waits for its transfer.
  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold        = draw_gap();
      out_stall_i = (hold != 0);
      repeat (hold) @(negedge clk_i);
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Both channels are looked at on the same edge: the result transfer is
  // checked first, then an input transfer queues its prediction.
  always @(posedge clk_i) begin : result_check
    ppu_tsa_pkg::result_t want, pred;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          $error("result transfer with nothing pending");
        end else begin
          want = due_results.pop_front();
          check_field("read_value", 16'(want.read_value), 16'(read_value_o));
          check_field("access_address", want.access_address, access_address_o);
          check_field("write_enable", 16'(want.write_enable), 16'(write_enable_o));
          check_field("vram_address", want.vram_address, vram_address_o);
          check_field("fine_x", 16'(want.fine_x), 16'(fine_x_o));
          check_field("nmi", 16'(want.nmi), 16'(nmi_o));
          check_field("vblank", 16'(want.vblank), 16'(vblank_o));
          check_field("pixel_valid", 16'(want.pixel_valid), 16'(pixel_valid_o));
          check_field("pixel_x", 16'(want.pixel_x), 16'(pixel_x_o));
          check_field("pixel_y", 16'(want.pixel_y), 16'(pixel_y_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = advance_video_state(ppu_tsa_pkg::op_e'(op_i), value_i, bus_data_i,
                                   sprite_zero_seen_i);
        if (row_typed) pred = row_want;
        due_results.insert(due_results.size(), pred);
      end
    end
  end

  initial begin : stimulus
    int unsigned n, i;
    logic [7:0]  m;
    in_valid_i         = 1'b0;
    op_i               = ppu_tsa_pkg::OP_TICK;
    value_i            = '0;
    bus_data_i         = '0;
    sprite_zero_seen_i = 1'b0;
    row_typed          = 1'b0;
    row_want           = '0;
    quiet              = 1'b0;
    mismatches         = 0;
    items_sent         = 0;

    vid_addr      = '0;
    tmp_addr      = '0;
    fine_scroll_q = '0;
    first_wr      = 1'b1;
    dot_q         = '0;
    line_q        = '0;
    phase_q       = ppu_tsa_pkg::PH_PRE;
    even_q        = 1'b1;
    vbl_q         = 1'b0;
    hit_q         = 1'b0;
    nmi_en_q      = 1'b0;
    inc32_q       = 1'b0;
    bg_q          = 1'b1;
    spr_q         = 1'b1;
    rd_buf_q      = '0;

    // Power-up values, every control bit at both extremes, the two-write
    // registers, palette and buffered reads, and the sprite-zero input on
    // items that ignore it.
    add_row(ppu_tsa_pkg::OP_STATUS_RD, 8'h00, 8'hFF, 1'b1, 1'b1, plain_result(0, 0, 0, 0, 0));
    add_row(ppu_tsa_pkg::OP_TICK,      8'hFF, 8'hFF, 1'b1, 1'b1, plain_result(0, 0, 0, 0, 0));
    add_row(ppu_tsa_pkg::OP_CTRL_WR,   8'hFF, 8'h00, 1'b0, 1'b1, plain_result(0, 0, 0, 0, 0));
    add_row(ppu_tsa_pkg::OP_MASK_WR,   8'h00, 8'h00, 1'b0, 1'b1, plain_result(0, 0, 0, 0, 0));
    add_row(ppu_tsa_pkg::OP_SCROLL_WR, 8'hFF, 8'h00, 1'b0, 1'b1, plain_result(0, 0, 0, 0, 7));
    add_row(ppu_tsa_pkg::OP_SCROLL_WR, 8'hFF, 8'h00, 1'b0, 1'b1, plain_result(0, 0, 0, 0, 7));
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'hFF, 8'h00, 1'b0, 1'b1, plain_result(0, 0, 0, 0, 7));
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'hFF, 8'h00, 1'b0, 1'b1,
            plain_result(0, 0, 0, 16'h3FFF, 7));
    add_row(ppu_tsa_pkg::OP_DATA_RD,   8'h00, 8'hA5, 1'b0, 1'b1,
            plain_result(8'hA5, 16'h3FFF, 0, 16'h401F, 7));
    add_row(ppu_tsa_pkg::OP_DATA_WR,   8'h5A, 8'h00, 1'b0, 1'b1,
            plain_result(0, 16'h401F, 1, 16'h403F, 7));
    add_row(ppu_tsa_pkg::OP_CTRL_WR,   8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_MASK_WR,   8'hFF, 8'h00, 1'b0, 1'b0, '0);
    // A status read between the two scroll writes restarts the sequence.
    add_row(ppu_tsa_pkg::OP_SCROLL_WR, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_STATUS_RD, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_DATA_RD,   8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_DATA_RD,   8'h00, 8'hFF, 1'b0, 1'b0, '0);
    // First palette address, then the last address below it.
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'h3F, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'h00, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_DATA_RD,   8'h00, 8'h3C, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'h3E, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_ADDR_WR,   8'hFF, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_DATA_RD,   8'h00, 8'h81, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_DATA_WR,   8'hFF, 8'h00, 1'b0, 1'b0, '0);
    add_row(ppu_tsa_pkg::OP_TICK,      8'h00, 8'h00, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].op, directed_rows[k].val, directed_rows[k].bus,
                directed_rows[k].seen, directed_rows[k].typed, directed_rows[k].want);
    end

    // Step by 32 from 0x3FE0 in the palette area across the 14-bit mirror
    // boundary, with reads and writes mixed.
    send_item(ppu_tsa_pkg::OP_CTRL_WR, 8'h04, 8'h00, 1'b0, 1'b0, '0);
    send_random(ppu_tsa_pkg::OP_STATUS_RD);
    send_item(ppu_tsa_pkg::OP_ADDR_WR, 8'h3F, 8'h00, 1'b0, 1'b0, '0);
    send_item(ppu_tsa_pkg::OP_ADDR_WR, 8'hE0, 8'h00, 1'b0, 1'b0, '0);
    for (i = 0; i < 40; i++) begin
      send_random($urandom_range(0, 1) ? ppu_tsa_pkg::OP_DATA_RD : ppu_tsa_pkg::OP_DATA_WR);
    end

    // Alternate bursts of any access under random idling with stall-free
    // tick runs: a scroll and control setup as software does it, then a run
    // of dot ticks through the prerender line and the first rendered lines.
    while (items_sent < 1600) begin
      if ($urandom_range(0, 1) == 0) begin
        n = $urandom_range(10, 50);
        for (i = 0; i < n; i++) begin
          send_random(($urandom_range(0, 9) < 4) ? ppu_tsa_pkg::OP_TICK :
                      ppu_tsa_pkg::op_e'($urandom_range(1, 7)));
        end
      end else begin
        quiet = 1'b1;
        send_random(ppu_tsa_pkg::OP_STATUS_RD);
        send_random(ppu_tsa_pkg::OP_SCROLL_WR);
        send_random(ppu_tsa_pkg::OP_SCROLL_WR);
        if ($urandom_range(0, 3) == 0) begin
          send_random(ppu_tsa_pkg::OP_ADDR_WR);
          send_random(ppu_tsa_pkg::OP_ADDR_WR);
        end
        m = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) m[7] = 1'b1;
        send_item(ppu_tsa_pkg::OP_CTRL_WR, m, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        // Rendering stays on in most runs so the copies and the address
        // steps show up.
        m = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) != 0) m = m | 8'h18;
        send_item(ppu_tsa_pkg::OP_MASK_WR, m, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        n = $urandom_range(1, 400);
        for (i = 0; i < n; i++) begin
          send_item(ppu_tsa_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0), 1'b0, '0);
        end
        quiet = 1'b0;
      end
    end
    in_valid_i = 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
